/* src/lzd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZ77 tuple decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int unsigned DIST_W      = 12;
    localparam int unsigned LEN_W       = 8;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned OUT_LANES   = 4;
    localparam int unsigned LANE_IDX_W  = 2;

    // Widest window offset over the whole parameter range.
    localparam int unsigned BACK_MAX_W  = 16;
    // Enough compare-and-subtract steps to reduce any distance by the
    // smallest window depth.
    localparam int unsigned MOD_STEPS   = 4;
    localparam int unsigned MOD_W       = 20;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [BACK_MAX_W-1:0] back;
        logic [LEN_W-1:0]      copy_len;
        logic [DATA_W-1:0]     lit;
        logic                  has_lit;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_COPY,
        ST_LIT
    } t_back_state;

endpackage

/* src/lzd_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_channels
// Handshake channels of the decoder: tuples in, packed byte groups out.
// ----------------------------------------------------------------------------
interface lzd_tuple_if;
    import lzd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  copy_length;
    logic [DATA_W-1:0] next_byte;
    logic              chunk_end;

    modport source (output valid, distance, copy_length, next_byte, chunk_end,
                    input ready);
    modport sink   (input valid, distance, copy_length, next_byte, chunk_end,
                    output ready);
endinterface

interface lzd_group_if;
    import lzd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  byte0;
    logic [DATA_W-1:0]  byte1;
    logic [DATA_W-1:0]  byte2;
    logic [DATA_W-1:0]  byte3;
    logic [COUNT_W-1:0] byte_count;
    logic               last;

    modport source (output valid, byte0, byte1, byte2, byte3, byte_count, last,
                    input ready);
    modport sink   (input valid, byte0, byte1, byte2, byte3, byte_count, last,
                    output ready);
endinterface

/* src/lzd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_front
// Accepts tuples, reduces the distance modulo the window depth and decides
// whether a copy and a literal take place. Tuples that give no bytes are
// taken and dropped here.
// ----------------------------------------------------------------------------
module lzd_front #(
    parameter int unsigned WINDOW_DEPTH = 4096
) (
    lzd_tuple_if.sink       i_tuple,
    output logic            o_push,
    output lzd_pkg::t_job   o_job,
    input  logic            i_full
);
    import lzd_pkg::*;

    logic [MOD_W-1:0] mod_val;
    logic             has_copy;

    always_comb begin
        mod_val = MOD_W'(i_tuple.distance);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (mod_val >= MOD_W'(WINDOW_DEPTH << k)) begin
                mod_val = mod_val - MOD_W'(WINDOW_DEPTH << k);
            end
        end
    end

    assign has_copy = (i_tuple.distance != '0) && (i_tuple.copy_length != '0);

    always_comb begin
        o_job.back     = mod_val[BACK_MAX_W-1:0];
        o_job.copy_len = has_copy ? i_tuple.copy_length : '0;
        o_job.lit      = i_tuple.next_byte;
        o_job.has_lit  = !(i_tuple.chunk_end && (i_tuple.next_byte == '0));
    end

    assign i_tuple.ready = !i_full;
    assign o_push        = i_tuple.valid && !i_full && (has_copy || o_job.has_lit);

endmodule

/* src/lzd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_queue
// Short first-in first-out queue of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module lzd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output lzd_pkg::t_job o_job,
    output logic          o_empty
);
    import lzd_pkg::*;

    t_job                   r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* src/lzd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_back
// Carries out jobs one byte per cycle, unless the output stalls, against the
// window memory, writes each byte back and packs the bytes into output groups.
// ----------------------------------------------------------------------------
module lzd_back #(
    parameter int unsigned WINDOW_DEPTH     = 4096,
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lzd_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    lzd_group_if.source   o_group
);
    import lzd_pkg::*;

    localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned LANES = (BYTES_PER_RESULT < 1) ? 1 :
                                    ((BYTES_PER_RESULT > OUT_LANES) ? OUT_LANES :
                                     BYTES_PER_RESULT);

    t_back_state          r_state;
    t_back_state          n_state;

    logic [DATA_W-1:0]    r_mem [WINDOW_DEPTH];
    logic [AW-1:0]        r_wp;
    logic                 r_wrapped;
    logic [DATA_W-1:0]    r_rd_data;
    logic                 r_rd_ok;
    logic [DATA_W-1:0]    r_last_byte;

    logic [AW-1:0]        r_back;
    logic [LEN_W-1:0]     r_left;
    logic [DATA_W-1:0]    r_lit;
    logic                 r_has_lit;

    logic [DATA_W-1:0]    r_acc [OUT_LANES];
    logic [LANE_IDX_W-1:0] r_acc_cnt;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_lane [OUT_LANES];
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_last;

    logic                 go;
    logic                 produce;
    logic                 rd_en;
    logic                 prod_final;
    logic [DATA_W-1:0]    prod_data;
    logic                 emit;
    logic [AW-1:0]        wp_inc;
    logic [AW-1:0]        rd_base;
    logic [AW:0]          rd_sum;
    logic [AW-1:0]        rd_addr;
    logic                 rd_ok;
    logic [DATA_W-1:0]    n_lane [OUT_LANES];

    assign go = !r_out_valid || o_group.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_job.copy_len != '0) ? ST_SETUP : ST_LIT;
                end
            end
            ST_SETUP: begin
                n_state = ST_COPY;
            end
            ST_COPY: begin
                if (go && (r_left == LEN_W'(1))) begin
                    n_state = r_has_lit ? ST_LIT : ST_IDLE;
                end
            end
            ST_LIT: begin
                if (go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        produce    = 1'b0;
        prod_final = 1'b0;
        prod_data  = r_lit;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_SETUP: begin
                rd_en = 1'b1;
            end
            ST_COPY: begin
                rd_en      = go;
                produce    = go;
                prod_final = (r_left == LEN_W'(1)) && !r_has_lit;
                if (r_back == AW'(1)) begin
                    prod_data = r_last_byte;
                end else begin
                    prod_data = r_rd_ok ? r_rd_data : '0;
                end
            end
            ST_LIT: begin
                produce    = go;
                prod_final = 1'b1;
                prod_data  = r_lit;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Read address for the next copied byte; the setup cycle reads for the
    // first byte, a copy cycle reads for the byte after the one it writes.
    assign wp_inc  = (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign rd_base = (r_state == ST_SETUP) ? r_wp : wp_inc;

    always_comb begin
        if (rd_base >= r_back) begin
            rd_sum = {1'b0, rd_base} - {1'b0, r_back};
        end else begin
            rd_sum = {1'b0, rd_base} + (AW + 1)'(WINDOW_DEPTH) - {1'b0, r_back};
        end
    end

    assign rd_addr = rd_sum[AW-1:0];
    assign rd_ok   = r_wrapped || (rd_addr < r_wp);

    assign emit = produce && ((r_acc_cnt == LANE_IDX_W'(LANES - 1)) || prod_final);

    always_comb begin
        for (int k = 0; k < OUT_LANES; k++) begin
            if (LANE_IDX_W'(k) < r_acc_cnt) begin
                n_lane[k] = r_acc[k];
            end else if (LANE_IDX_W'(k) == r_acc_cnt) begin
                n_lane[k] = prod_data;
            end else begin
                n_lane[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_last_byte <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (produce) begin
                r_wp        <= wp_inc;
                r_last_byte <= prod_data;
                if (r_wp == AW'(WINDOW_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
                if (emit) begin
                    r_acc_cnt <= '0;
                end else begin
                    r_acc_cnt <= r_acc_cnt + LANE_IDX_W'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_group.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_back    <= i_job.back[AW-1:0];
            r_left    <= i_job.copy_len;
            r_lit     <= i_job.lit;
            r_has_lit <= i_job.has_lit;
        end else if (produce && (r_state == ST_COPY)) begin
            r_left <= r_left - LEN_W'(1);
        end
        if (produce && !emit) begin
            r_acc[r_acc_cnt] <= prod_data;
        end
        if (emit) begin
            r_out_lane  <= n_lane;
            r_out_count <= COUNT_W'(r_acc_cnt) + COUNT_W'(1);
            r_out_last  <= prod_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_mem[r_wp] <= prod_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= rd_ok;
        end
    end

    assign o_group.valid      = r_out_valid;
    assign o_group.byte0      = r_out_lane[0];
    assign o_group.byte1      = r_out_lane[1];
    assign o_group.byte2      = r_out_lane[2];
    assign o_group.byte3      = r_out_lane[3];
    assign o_group.byte_count = r_out_count;
    assign o_group.last       = r_out_last;

endmodule

/* src/lz77_tuple_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_tuple_decoder_core
// LZ77 tuple decoder with a persistent sliding window and packed byte output.
//
// Channel   Dir  Handshake     Payload
// i_tuple   in   valid/ready   distance, copy_length, next_byte, chunk_end
// o_group   out  valid/ready   byte0..byte3, byte_count, last
//
// The back end handles one byte per cycle, unless the output stalls, on a
// one-write, one-read window memory, taking each job in the idle state, then a
// copy through setup and copy states and a kept literal in the literal state.
// Reset clears the write pointer and the written-once flag; window slots not
// yet written read as zero, so no clearing pass is needed.
// A four-entry queue lets the front keep taking tuples while the back works.
// ----------------------------------------------------------------------------
module lz77_tuple_decoder_core #(
    parameter int unsigned WINDOW_DEPTH     = 4096,
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzd_tuple_if.sink   i_tuple,
    lzd_group_if.source o_group
);
    import lzd_pkg::*;

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    lzd_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .i_tuple (i_tuple),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    lzd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    lzd_back #(
        .WINDOW_DEPTH     (WINDOW_DEPTH),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_group (o_group)
    );

endmodule

/* tb/tb_lz77_tuple_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz77_tuple_decoder_core
// Sends LZ77 tuples into the decoder and checks every packed byte group that
// comes out against a local window model. Directed tuples cover the extremes,
// overlapping copies, copies from unwritten slots and dropped literals. Random
// tuples then run through phases with sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lz77_tuple_decoder_core;
    import lzd_pkg::*;

    localparam int unsigned WINDOW_SIZE = 4096;
    localparam int unsigned GROUP_BYTES = 4;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned RANDOM_PER_PHASE = 110;

    typedef struct packed {
        logic [OUT_LANES-1:0][DATA_W-1:0] lanes;
        logic [COUNT_W-1:0]               count;
        logic                             last;
    } t_group;

    class byte_group_scoreboard;
        logic [DATA_W-1:0] window [WINDOW_SIZE];
        logic [DIST_W-1:0] wr_ptr;
        t_group            expected_groups [$];
        int unsigned       errors;
        int unsigned       groups_seen;

        function new();
            foreach (window[i]) window[i] = '0;
            wr_ptr      = '0;
            errors      = 0;
            groups_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_groups.size();
        endfunction

        function void note_tuple(logic [DIST_W-1:0] tup_dist, logic [LEN_W-1:0] len,
                                 logic [DATA_W-1:0] lit, logic chunk_last);
            logic [DATA_W-1:0] produced [$];
            logic [DATA_W-1:0] b;
            logic [DIST_W-1:0] rd_addr;
            t_group            grp;
            int unsigned       n;

            if (tup_dist != 0) begin
                for (int unsigned i = 0; i < len; i++) begin
                    rd_addr = wr_ptr - tup_dist;
                    b = window[rd_addr];
                    window[wr_ptr] = b;
                    wr_ptr = wr_ptr + 1'b1;
                    produced.insert(produced.size(), b);
                end
            end
            if (!(chunk_last && lit == 0)) begin
                window[wr_ptr] = lit;
                wr_ptr = wr_ptr + 1'b1;
                produced.insert(produced.size(), lit);
            end
            for (int unsigned base = 0; base < produced.size(); base += GROUP_BYTES) begin
                n = produced.size() - base;
                if (n > GROUP_BYTES) n = GROUP_BYTES;
                grp = '0;
                for (int unsigned k = 0; k < n; k++) grp.lanes[k] = produced[base + k];
                grp.count = COUNT_W'(n);
                grp.last  = (base + GROUP_BYTES >= produced.size());
                expected_groups.insert(expected_groups.size(), grp);
            end
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("Mismatch in group %0d, %s: got 0x%0h, expected 0x%0h",
                     groups_seen, what, got, want);
            errors++;
        endtask

        task check_group(logic [DATA_W-1:0] b0, logic [DATA_W-1:0] b1,
                         logic [DATA_W-1:0] b2, logic [DATA_W-1:0] b3,
                         logic [COUNT_W-1:0] cnt, logic lst);
            t_group want;
            t_group got;

            got.lanes = {b3, b2, b1, b0};
            got.count = cnt;
            got.last  = lst;
            if (expected_groups.size() == 0) begin
                report_mismatch("unexpected group, byte_count", 32'(got.count), 0);
            end else begin
                want = expected_groups.pop_front();
                for (int k = 0; k < OUT_LANES; k++) begin
                    if (got.lanes[k] !== want.lanes[k])
                        report_mismatch($sformatf("byte%0d", k), 32'(got.lanes[k]),
                                        32'(want.lanes[k]));
                end
                if (got.count !== want.count)
                    report_mismatch("byte_count", 32'(got.count), 32'(want.count));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
            groups_seen++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;

    byte_group_scoreboard sb;

    lzd_tuple_if tup ();
    lzd_group_if grp ();

    lz77_tuple_decoder_core #(
        .WINDOW_DEPTH     (WINDOW_SIZE),
        .BYTES_PER_RESULT (GROUP_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tuple (tup),
        .o_group (grp)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic send_tuple(logic [DIST_W-1:0] tup_dist, logic [LEN_W-1:0] len,
                              logic [DATA_W-1:0] lit, logic chunk_last);
        while ($urandom_range(99) < send_idle_pct) begin
            tup.valid = 1'b0;
            @(negedge i_clk);
        end
        tup.valid       = 1'b1;
        tup.distance    = tup_dist;
        tup.copy_length = len;
        tup.next_byte   = lit;
        tup.chunk_end   = chunk_last;
        do @(posedge i_clk); while (!tup.ready);
        sb.note_tuple(tup_dist, len, lit, chunk_last);
        @(negedge i_clk);
    endtask

    task automatic send_random_tuple();
        logic [DIST_W-1:0] tup_dist;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] lit;
        logic              chunk_last;
        int unsigned       pick;

        pick = $urandom_range(99);
        if (pick < 50)      tup_dist = DIST_W'($urandom_range(32, 1));
        else if (pick < 78) tup_dist = DIST_W'($urandom_range(4095, 33));
        else if (pick < 90) tup_dist = '0;
        else                tup_dist = DIST_W'($urandom_range(4095, 3968));
        pick = $urandom_range(99);
        if (pick < 70)      len = LEN_W'($urandom_range(24, 0));
        else if (pick < 95) len = LEN_W'($urandom_range(100, 25));
        else                len = LEN_W'($urandom_range(255, 101));
        lit        = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
        chunk_last = ($urandom_range(7) == 0);
        send_tuple(tup_dist, len, lit, chunk_last);
    endtask

    initial begin
        grp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            grp.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && grp.valid && grp.ready)
            sb.check_group(grp.byte0, grp.byte1, grp.byte2, grp.byte3,
                           grp.byte_count, grp.last);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_lz77_tuple_decoder_core NOT OK");
        $finish;
    end

    initial begin
        sb              = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        tup.valid       = 1'b0;
        tup.distance    = '0;
        tup.copy_length = '0;
        tup.next_byte   = '0;
        tup.chunk_end   = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_tuple(12'd100,  8'd5,   8'h41, 1'b0);
        send_tuple(12'd0,    8'd0,   8'h00, 1'b0);
        send_tuple(12'd0,    8'd200, 8'hFF, 1'b0);
        send_tuple(12'd1,    8'd255, 8'h5A, 1'b0);
        send_tuple(12'd2,    8'd7,   8'h12, 1'b1);
        send_tuple(12'd0,    8'd0,   8'h00, 1'b1);
        send_tuple(12'd5,    8'd0,   8'h00, 1'b1);
        send_tuple(12'd0,    8'd9,   8'h00, 1'b1);
        send_tuple(12'd4095, 8'd255, 8'h00, 1'b1);
        send_tuple(12'd3,    8'd3,   8'hAA, 1'b0);
        send_tuple(12'd4095, 8'd1,   8'h55, 1'b0);
        send_tuple(12'd1,    8'd1,   8'h80, 1'b1);
        send_tuple(12'd1,    8'd2,   8'h09, 1'b0);
        send_tuple(12'd16,   8'd4,   8'h01, 1'b0);
        send_tuple(12'd7,    8'd0,   8'h7F, 1'b0);
        send_tuple(12'd2048, 8'd100, 8'hC3, 1'b1);
        send_tuple(12'hAAA,  8'h55,  8'h55, 1'b0);
        send_tuple(12'h555,  8'hAA,  8'hAA, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_tuple();
        end
        tup.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("tb_lz77_tuple_decoder_core OK");
        end else begin
            $display("tb_lz77_tuple_decoder_core NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/lzd_pkg.sv
src/lzd_channels.sv
src/lzd_front.sv
src/lzd_queue.sv
src/lzd_back.sv
src/lz77_tuple_decoder_core.sv
tb/tb_lz77_tuple_decoder_core.sv
